FILE: hw/rtl/fpie_pkg.sv
// Shared types, constants and codes for the fixed-point infix evaluator.
package fpie_pkg;

    localparam int NestDepth = 16;
    localparam int LvW       = $clog2(NestDepth);
    localparam int DivSteps  = 64;

    // parse phases
    localparam logic [1:0] PH_OPERAND = 2'd0;
    localparam logic [1:0] PH_INT     = 2'd1;
    localparam logic [1:0] PH_FRAC    = 2'd2;
    localparam logic [1:0] PH_AFTER   = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_MISSING  = 3'd1;
    localparam logic [2:0] ST_PAREN    = 3'd2;
    localparam logic [2:0] ST_DIVZERO  = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;
    localparam logic [2:0] ST_SYNTAX   = 3'd5;
    localparam logic [2:0] ST_DEEP     = 3'd6;
    localparam logic [2:0] ST_BLANK    = 3'd7;

    // multiplicative operator codes
    localparam logic [1:0] MOP_NONE = 2'd0;
    localparam logic [1:0] MOP_MUL  = 2'd1;
    localparam logic [1:0] MOP_DIV  = 2'd2;
    localparam logic [1:0] MOP_MOD  = 2'd3;

    // additive operator codes
    localparam logic [1:0] AOP_NONE = 2'd0;
    localparam logic [1:0] AOP_ADD  = 2'd1;
    localparam logic [1:0] AOP_SUB  = 2'd2;

    // character codes
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // divider request and response
    typedef struct packed {
        logic        start;
        logic [63:0] num;   // signed dividend
        logic [31:0] den;   // signed divisor, nonzero
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;   // signed quotient, truncated
        logic [31:0] rem;   // signed remainder
    } div_rsp_t;

endpackage

FILE: hw/rtl/fpie_div.sv
// Radix-2 restoring divider, 64-bit by 32-bit signed, one bit per cycle.
module fpie_div
    import fpie_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic        busy_reg;
    logic [6:0]  cnt_reg;
    logic [63:0] q_reg;
    logic [32:0] r_reg;
    logic [31:0] d_reg;
    logic        qneg_reg;
    logic        rneg_reg;
    logic        done_reg;

    logic [32:0] shifted;
    logic [33:0] diff;
    logic [63:0] num_abs;

    assign num_abs = req.num[63] ? (64'd0 - req.num) : req.num;
    assign shifted = {r_reg[31:0], q_reg[63]};
    assign diff    = {1'b0, shifted} - {2'b00, d_reg};

    // iterate one quotient bit a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'(DivSteps);
                q_reg    <= num_abs;
                r_reg    <= '0;
                d_reg    <= req.den[31] ? (32'd0 - req.den) : req.den;
                qneg_reg <= req.num[63] ^ req.den[31];
                rneg_reg <= req.num[63];
            end
            else if (busy_reg)
            begin
                if (diff[33])
                begin
                    r_reg <= shifted;
                    q_reg <= {q_reg[62:0], 1'b0};
                end
                else
                begin
                    r_reg <= diff[32:0];
                    q_reg <= {q_reg[62:0], 1'b1};
                end
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = qneg_reg ? (64'd0 - q_reg) : q_reg;
    assign rsp.rem  = rneg_reg ? (32'd0 - r_reg[31:0]) : r_reg[31:0];

endmodule

FILE: hw/rtl/fixed_point_infix_expression_evaluator.sv
// Top level of the fixed-point infix expression evaluator.
//
//  channel  dir  fields
//  s_axis   in   tdata[7:0]=ch, tlast=last
//  m_axis   out  tdata[34:0]={status,value} in 40 bits, status at [34:32]
//
// A plain character passes through S_CHAR before s_axis_tready is high again.
// Ending a number or closing a paren applies a factor: through S_FACT and S_END
// without an operator, adding one pass of the shared 64-step divider (*, / and %)
// with one. A ')' that ends a number can need two passes.
// s_axis_tready is low while a request is worked on or a result waits on m_axis.
// Reset clears the sequencer, level, parse and error state and level 0; deeper levels are cleared when opened.
module fixed_point_infix_expression_evaluator
    import fpie_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // ch
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // value[31:0], status[34:32], zero pad
    output logic        m_axis_tlast
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CHAR  = 9'b000000010,
        S_CLOSE = 9'b000000100,     // character after an operand
        S_FACT  = 9'b000001000,
        S_MULW  = 9'b000010000,     // start the divider
        S_DIV1  = 9'b000100000,     // wait for the divider
        S_END   = 9'b001000000,
        S_FINAL = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t state_reg;

    // level stacks
    logic [31:0] sum_mem  [NestDepth];
    logic [31:0] prod_mem [NestDepth];
    logic [1:0]  aop_mem  [NestDepth];
    logic [1:0]  mop_mem  [NestDepth];
    logic        neg_mem  [NestDepth];

    logic [LvW:0] lv_reg;
    logic [1:0]   phase_reg;
    logic [31:0]  acc_reg;
    logic [1:0]   fpos_reg;
    logic         digits_reg;
    logic [2:0]   err_reg;
    logic         nonblank_reg;
    logic [7:0]   ch_reg;
    logic         last_reg;
    logic [31:0]  fact_reg;     // factor being applied
    logic [1:0]   op_reg;       // operator of the factor being applied
    logic [63:0]  prod64_reg;
    logic [31:0]  res_reg;
    logic         close_reg;    // factor came from ')' or the end of input, ch consumed

    div_req_t dreq;
    div_rsp_t drsp;

    fpie_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    logic [LvW-1:0] lv, lv_up;
    assign lv    = lv_reg[LvW-1:0];
    assign lv_up = lv + 1'b1;

    logic [31:0] cur_sum, cur_prod;
    logic [1:0]  cur_aop, cur_mop;
    logic        cur_neg;
    assign cur_sum  = sum_mem[lv];
    assign cur_prod = prod_mem[lv];
    assign cur_aop  = aop_mem[lv];
    assign cur_mop  = mop_mem[lv];
    assign cur_neg  = neg_mem[lv];

    // level total
    logic [31:0] total;
    always_comb
    begin
        case (cur_aop)
            AOP_NONE: total = cur_prod;
            AOP_ADD:  total = cur_sum + cur_prod;
            default:  total = cur_sum - cur_prod;
        endcase
    end

    // character classes
    logic is_sp, is_dig, is_mop, is_aop;
    logic [3:0] dig;
    assign is_sp  = (ch_reg == CH_SPACE) || (ch_reg == CH_TAB);
    assign is_dig = (ch_reg >= CH_ZERO) && (ch_reg <= CH_NINE);
    assign is_mop = (ch_reg == CH_STAR) || (ch_reg == CH_SLASH) || (ch_reg == CH_PCT);
    assign is_aop = (ch_reg == CH_PLUS) || (ch_reg == CH_MINUS);
    assign dig    = 4'(ch_reg - CH_ZERO);

    // number accumulation
    logic [35:0] int_sum, frac_sum;
    logic [9:0]  fw;
    always_comb
    begin
        case (fpos_reg)
            2'd0:    fw = 10'd100;
            2'd1:    fw = 10'd10;
            default: fw = 10'd1;
        endcase
        int_sum  = 36'(acc_reg) * 36'd10 + 36'(dig) * 36'd1000;
        frac_sum = 36'(acc_reg) + 36'(dig) * 36'(fw);
    end

    // signed factor and 32x32 product
    logic [31:0]        fneg;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p, divnum;
    assign fneg   = cur_neg ? (32'd0 - fact_reg) : fact_reg;
    assign mul_a  = cur_prod;
    assign mul_b  = fneg;
    assign mul_p  = mul_a * mul_b;
    assign divnum = 64'(signed'(cur_prod)) * 64'sd1000;

    // exact quotient must lie in the 32-bit range
    logic q_fit, q_edge, q_ok;
    assign q_fit  = (drsp.quo[63:31] == '0) || (drsp.quo[63:31] == '1);
    assign q_edge = ((drsp.quo[30:0] == '1) && !drsp.quo[63])
                 || ((drsp.quo[30:0] == '0) && drsp.quo[63]);
    assign q_ok   = q_fit && !(q_edge && (drsp.rem != '0));

    logic in_acc, out_acc;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = {5'd0, err_reg, (err_reg != ST_OK) ? 32'd0 : res_reg};
    assign m_axis_tlast  = 1'b1;

    // divider operands
    always_comb
    begin
        dreq.start = (state_reg == S_MULW);
        dreq.num   = 64'(signed'(cur_prod));
        dreq.den   = fact_reg;
        if (op_reg == MOP_MUL)
        begin
            dreq.num = prod64_reg;
            dreq.den = 32'd1000;
        end
        else if (op_reg == MOP_DIV)
            dreq.num = divnum;
    end

    // after a factor or a finished char: decide next state
    function automatic state_t after_char(input logic lst);
        after_char = lst ? S_FINAL : S_IDLE;
    endfunction

    // main sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            lv_reg       <= '0;
            phase_reg    <= PH_OPERAND;
            acc_reg      <= '0;
            fpos_reg     <= '0;
            digits_reg   <= 1'b0;
            err_reg      <= ST_OK;
            nonblank_reg <= 1'b0;
            close_reg    <= 1'b0;
            sum_mem[0]   <= '0;
            prod_mem[0]  <= '0;
            aop_mem[0]   <= AOP_NONE;
            mop_mem[0]   <= MOP_NONE;
            neg_mem[0]   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        ch_reg    <= s_axis_tdata;
                        last_reg  <= s_axis_tlast;
                        state_reg <= S_CHAR;
                    end
                end
                S_CHAR:
                begin
                    if (!is_sp)
                        nonblank_reg <= 1'b1;
                    if (err_reg != ST_OK)
                        state_reg <= after_char(last_reg);
                    else if (phase_reg == PH_AFTER)
                        state_reg <= S_CLOSE;
                    else if (phase_reg == PH_OPERAND)
                    begin
                        state_reg <= after_char(last_reg);
                        if (ch_reg == CH_MINUS)
                            neg_mem[lv] <= ~cur_neg;
                        else if (ch_reg == CH_LPAREN)
                        begin
                            if (32'(lv_reg) + 32'd1 >= 32'(NestDepth))
                                err_reg <= ST_DEEP;
                            else
                            begin
                                lv_reg          <= lv_reg + 1'b1;
                                sum_mem[lv_up]  <= '0;
                                prod_mem[lv_up] <= '0;
                                aop_mem[lv_up]  <= AOP_NONE;
                                mop_mem[lv_up]  <= MOP_NONE;
                                neg_mem[lv_up]  <= 1'b0;
                            end
                        end
                        else if (is_dig)
                        begin
                            acc_reg    <= 32'(dig) * 32'd1000;
                            digits_reg <= 1'b1;
                            fpos_reg   <= '0;
                            phase_reg  <= PH_INT;
                        end
                        else if (ch_reg == CH_DOT)
                        begin
                            acc_reg    <= '0;
                            digits_reg <= 1'b0;
                            fpos_reg   <= '0;
                            phase_reg  <= PH_FRAC;
                        end
                        else if (!(is_sp || ch_reg == CH_PLUS))
                            err_reg <= ST_MISSING;
                    end
                    else if (is_dig)
                    begin
                        // digit inside a number
                        state_reg  <= after_char(last_reg);
                        digits_reg <= 1'b1;
                        if (phase_reg == PH_INT)
                        begin
                            if (int_sum > 36'h7fffffff)
                                err_reg <= ST_OVERFLOW;
                            else
                                acc_reg <= int_sum[31:0];
                        end
                        else if (fpos_reg != 2'd3)
                        begin
                            if (frac_sum > 36'h7fffffff)
                                err_reg <= ST_OVERFLOW;
                            else
                            begin
                                acc_reg  <= frac_sum[31:0];
                                fpos_reg <= fpos_reg + 2'd1;
                            end
                        end
                    end
                    else if (ch_reg == CH_DOT && phase_reg == PH_INT)
                    begin
                        state_reg <= after_char(last_reg);
                        phase_reg <= PH_FRAC;
                        fpos_reg  <= '0;
                    end
                    else if (phase_reg == PH_FRAC && !digits_reg)
                    begin
                        state_reg <= after_char(last_reg);
                        err_reg   <= ST_MISSING;
                    end
                    else
                    begin
                        // number ends; the char is handled after the factor
                        fact_reg  <= acc_reg;
                        close_reg <= 1'b0;
                        state_reg <= S_FACT;
                    end
                end
                S_CLOSE:
                begin
                    // after-operand character
                    if (ch_reg == CH_RPAREN && lv_reg != '0)
                    begin
                        fact_reg  <= total;
                        lv_reg    <= lv_reg - 1'b1;
                        close_reg <= 1'b1;
                        state_reg <= S_FACT;
                    end
                    else
                    begin
                        state_reg <= after_char(last_reg);
                        if (is_mop)
                        begin
                            mop_mem[lv] <= (ch_reg == CH_STAR)  ? MOP_MUL :
                                           (ch_reg == CH_SLASH) ? MOP_DIV : MOP_MOD;
                            phase_reg <= PH_OPERAND;
                        end
                        else if (is_aop)
                        begin
                            sum_mem[lv]  <= total;
                            aop_mem[lv]  <= (ch_reg == CH_PLUS) ? AOP_ADD : AOP_SUB;
                            prod_mem[lv] <= '0;
                            phase_reg    <= PH_OPERAND;
                        end
                        else if (!is_sp)
                            err_reg <= (lv_reg != '0) ? ST_PAREN : ST_SYNTAX;
                    end
                end
                S_FACT:
                begin
                    // apply sign, then operator
                    neg_mem[lv] <= 1'b0;
                    mop_mem[lv] <= MOP_NONE;
                    phase_reg   <= PH_AFTER;
                    fact_reg    <= fneg;
                    op_reg      <= cur_mop;
                    prod64_reg  <= mul_p;
                    if (cur_mop == MOP_NONE)
                    begin
                        prod_mem[lv] <= fneg;
                        state_reg    <= S_END;
                    end
                    else if (cur_mop != MOP_MUL && fact_reg == '0)
                    begin
                        err_reg   <= ST_DIVZERO;
                        state_reg <= S_END;
                    end
                    else
                        state_reg <= S_MULW;
                end
                S_MULW:
                    state_reg <= S_DIV1;
                S_DIV1:
                begin
                    if (drsp.done)
                    begin
                        state_reg <= S_END;
                        if (op_reg == MOP_MOD)
                            prod_mem[lv] <= drsp.rem;
                        else if (!q_ok)
                            err_reg <= ST_OVERFLOW;
                        else
                            prod_mem[lv] <= drsp.quo[31:0];
                    end
                end
                S_END:
                begin
                    // factor done; the char that ended a number comes next
                    if (!close_reg && err_reg == ST_OK)
                        state_reg <= S_CLOSE;
                    else
                        state_reg <= after_char(last_reg);
                end
                S_FINAL:
                begin
                    if (err_reg == ST_OK && nonblank_reg
                        && (phase_reg == PH_INT || phase_reg == PH_FRAC)
                        && !(phase_reg == PH_FRAC && !digits_reg))
                    begin
                        // close the pending number, then come back here
                        fact_reg  <= acc_reg;
                        close_reg <= 1'b1;
                        state_reg <= S_FACT;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                        if (err_reg == ST_OK)
                        begin
                            if (!nonblank_reg)
                                err_reg <= ST_BLANK;
                            else if (phase_reg != PH_AFTER)
                                err_reg <= ST_MISSING;
                            else if (lv_reg != '0)
                                err_reg <= ST_PAREN;
                            else
                                res_reg <= total;
                        end
                    end
                end
                S_OUT:
                begin
                    if (out_acc)
                    begin
                        state_reg    <= S_IDLE;
                        lv_reg       <= '0;
                        phase_reg    <= PH_OPERAND;
                        acc_reg      <= '0;
                        fpos_reg     <= '0;
                        digits_reg   <= 1'b0;
                        err_reg      <= ST_OK;
                        nonblank_reg <= 1'b0;
                        sum_mem[0]   <= '0;
                        prod_mem[0]  <= '0;
                        aop_mem[0]   <= AOP_NONE;
                        mop_mem[0]   <= MOP_NONE;
                        neg_mem[0]   <= 1'b0;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
